>>> rtl/adaptive_huffman_encoder_core_macros.svh
// Assertion helpers for the encoder checker
`ifndef ADAPTIVE_HUFFMAN_ENCODER_CORE_MACROS_SVH
`define ADAPTIVE_HUFFMAN_ENCODER_CORE_MACROS_SVH

// Checked outside reset
`define HUFFENC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked also while reset is held
`define HUFFENC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/huffenc_pkg.sv
package huffenc_pkg;
    localparam int WEIGHT_W = 32;
    typedef logic [WEIGHT_W-1:0] t_weight;
    localparam t_weight WEIGHT_MAX = '1;
endpackage

>>> rtl/huffenc_front.sv
module huffenc_front #(
    parameter int SYMBOL_BITS = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SYMBOL_BITS-1:0] i_symbol,
    output logic                   o_q_valid,
    output logic [SYMBOL_BITS-1:0] o_q_symbol,
    input  logic                   i_q_pop
);
    logic [SYMBOL_BITS-1:0] r_buf [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;
    logic                   push;
    logic                   pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_symbol = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> rtl/huffenc_back.sv
module huffenc_back #(
    parameter int SYMBOL_BITS = 7,
    parameter int MAX_NODES   = 256,
    parameter int CHUNK_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  logic [SYMBOL_BITS-1:0]             i_q_symbol,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [CHUNK_BITS-1:0]              o_code_chunk,
    output logic [$clog2(CHUNK_BITS+1)-1:0]    o_chunk_bits,
    output logic                               o_last_chunk,
    output logic                               o_overflow
);
    import huffenc_pkg::*;

    localparam int SB   = SYMBOL_BITS;
    localparam int NW   = $clog2(MAX_NODES);
    localparam int TW   = $clog2(MAX_NODES + 1);
    localparam int NSYM = 1 << SYMBOL_BITS;
    localparam int RW   = $clog2(MAX_NODES + SYMBOL_BITS + 1);
    localparam int CW   = $clog2(CHUNK_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LEAF, S_WP, S_WR, S_UPD, S_SP0, S_SP1, S_SP2, S_CL0, S_CL1,
        S_BF0, S_BF1, S_BF2, S_BF3, S_SW0, S_SW1, S_SW2, S_SW3, S_SW4, S_INC, S_EMIT
    } t_state;

    // tree store
    t_weight        m_w     [MAX_NODES];
    logic [NW-1:0]  m_par   [MAX_NODES];
    logic [NW-1:0]  m_left  [MAX_NODES];
    logic [NW-1:0]  m_right [MAX_NODES];
    logic           m_inner [MAX_NODES];
    logic [NW-1:0]  m_q     [MAX_NODES];
    logic [NW-1:0]  m_leaf  [NSYM];

    t_weight        rd_w_mem;
    t_weight        w_rd;
    logic [NW-1:0]  rd_par, rd_left, rd_right, rd_q, rd_leaf;
    logic           rd_inner;

    logic           w_we, par_we, left_we, right_we, inner_we, q_we, leaf_we;
    logic [NW-1:0]  w_wa, par_wa, left_wa, right_wa, inner_wa, q_wa;
    logic [SB-1:0]  leaf_wa, leaf_ra;
    t_weight        w_wd;
    logic [NW-1:0]  par_wd, left_wd, right_wd, q_wd, leaf_wd;
    logic           inner_wd;
    logic [NW-1:0]  w_ra, par_ra, left_ra, right_ra, inner_ra, q_ra;

    t_state          r_state, n_state;
    logic [SB-1:0]   r_sym, n_sym, r_raw, n_raw;
    logic            r_seen, n_seen;
    logic [NSYM-1:0] r_seen_bits, n_seen_bits;
    logic [NW-1:0]   r_n, n_n, r_p, n_p, r_leaf, n_leaf, r_esc, n_esc, r_old, n_old;
    logic [NW-1:0]   r_c, n_c, r_par, n_par, r_x, n_x, r_m, n_m, r_pb, n_pb;
    logic [TW-1:0]   r_depth, n_depth, r_guard, n_guard, r_used, n_used;
    logic [TW-1:0]   r_head, n_head, r_tail, n_tail;
    logic [MAX_NODES-1:0] r_shift, n_shift;
    logic            r_ovf, n_ovf, r_aleft, n_aleft, r_bleft, n_bleft, r_w_ra0, n_w_ra0;
    t_weight         r_root_w, n_root_w, r_wt, n_wt, r_w, n_w;
    logic [RW-1:0]   r_rem, n_rem;
    logic [CHUNK_BITS-1:0] r_chunk, n_chunk, r_out_chunk, n_out_chunk;
    logic [CW-1:0]   r_cnt, n_cnt, r_out_bits, n_out_bits;
    logic            r_out_valid, n_out_valid, r_out_last, n_out_last;
    logic            r_out_ovf, n_out_ovf;

    assign w_rd         = r_w_ra0 ? r_root_w : rd_w_mem;
    assign o_out_valid  = r_out_valid;
    assign o_code_chunk = r_out_chunk;
    assign o_chunk_bits = r_out_bits;
    assign o_last_chunk = r_out_last;
    assign o_overflow   = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (w_we && (w_wa != '0)) begin
            m_w[w_wa] <= w_wd;
        end
        rd_w_mem <= m_w[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            m_par[par_wa] <= par_wd;
        end
        rd_par <= m_par[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (left_we) begin
            m_left[left_wa] <= left_wd;
        end
        rd_left <= m_left[left_ra];
    end

    always_ff @(posedge i_clk) begin
        if (right_we) begin
            m_right[right_wa] <= right_wd;
        end
        rd_right <= m_right[right_ra];
    end

    always_ff @(posedge i_clk) begin
        if (inner_we) begin
            m_inner[inner_wa] <= inner_wd;
        end
        rd_inner <= m_inner[inner_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_q[q_wa] <= q_wd;
        end
        rd_q <= m_q[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            m_leaf[leaf_wa] <= leaf_wd;
        end
        rd_leaf <= m_leaf[leaf_ra];
    end

    always_comb begin
        logic [NW-1:0] cur;
        logic [NW-1:0] new_leaf;
        logic [NW-1:0] new_esc;
        logic          e_bit;
        logic [CHUNK_BITS-1:0] sh_chunk;

        cur      = r_seen ? rd_leaf : r_esc;
        new_leaf = r_used[NW-1:0];
        new_esc  = r_used[NW-1:0] + NW'(1);
        e_bit    = (r_depth != '0) ? r_shift[MAX_NODES-1] : r_raw[SB-1];
        sh_chunk = {r_chunk[CHUNK_BITS-2:0], e_bit};

        n_state = r_state;  n_sym = r_sym;     n_raw = r_raw;     n_seen = r_seen;
        n_seen_bits = r_seen_bits;
        n_n = r_n;  n_p = r_p;  n_leaf = r_leaf;  n_esc = r_esc;  n_old = r_old;
        n_c = r_c;  n_par = r_par;  n_x = r_x;  n_m = r_m;  n_pb = r_pb;
        n_depth = r_depth;  n_guard = r_guard;  n_used = r_used;
        n_head = r_head;  n_tail = r_tail;  n_shift = r_shift;
        n_ovf = r_ovf;  n_aleft = r_aleft;  n_bleft = r_bleft;
        n_wt = r_wt;  n_w = r_w;  n_rem = r_rem;  n_chunk = r_chunk;  n_cnt = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_chunk = r_out_chunk;  n_out_bits = r_out_bits;
        n_out_last = r_out_last;  n_out_ovf = r_out_ovf;

        o_q_pop = 1'b0;
        w_we = 1'b0;  par_we = 1'b0;  left_we = 1'b0;  right_we = 1'b0;
        inner_we = 1'b0;  q_we = 1'b0;  leaf_we = 1'b0;
        w_wa = '0;  par_wa = '0;  left_wa = '0;  right_wa = '0;  inner_wa = '0;
        q_wa = '0;  leaf_wa = '0;
        w_wd = '0;  par_wd = '0;  left_wd = '0;  right_wd = '0;  inner_wd = 1'b0;
        q_wd = '0;  leaf_wd = '0;
        w_ra = '0;  par_ra = '0;  left_ra = '0;  right_ra = '0;  inner_ra = '0;
        q_ra = '0;  leaf_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_sym   = i_q_symbol;
                    n_seen  = r_seen_bits[i_q_symbol];
                    leaf_ra = i_q_symbol;
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                n_leaf  = rd_leaf;
                n_n     = cur;
                n_raw   = r_sym;
                n_depth = '0;
                if (cur == '0) begin
                    n_state = S_UPD;
                end else begin
                    par_ra  = cur;
                    n_state = S_WP;
                end
            end
            S_WP: begin
                n_p      = rd_par;
                right_ra = rd_par;
                n_state  = S_WR;
            end
            S_WR: begin
                n_shift = {rd_right == r_n, r_shift[MAX_NODES-1:1]};
                n_depth = r_depth + TW'(1);
                n_n     = r_p;
                if ((r_p == '0) || (r_depth == TW'(MAX_NODES - 1))) begin
                    n_state = S_UPD;
                end else begin
                    par_ra  = r_p;
                    n_state = S_WP;
                end
            end
            S_UPD: begin
                n_rem   = RW'(r_depth) + (r_seen ? RW'(0) : RW'(SB));
                n_cnt   = '0;
                n_chunk = '0;
                n_guard = '0;
                if (r_ovf || (r_root_w == WEIGHT_MAX)) begin
                    n_ovf   = 1'b1;
                    n_state = S_EMIT;
                end else if (r_seen) begin
                    n_c     = r_leaf;
                    n_state = S_CL0;
                end else if (r_used > TW'(MAX_NODES - 2)) begin
                    n_state = S_EMIT;
                end else begin
                    n_old   = r_esc;
                    n_state = S_SP0;
                end
            end
            S_SP0: begin
                w_we = 1'b1;      w_wa = new_leaf;     w_wd = t_weight'(1);
                par_we = 1'b1;    par_wa = new_leaf;   par_wd = r_old;
                inner_we = 1'b1;  inner_wa = new_leaf; inner_wd = 1'b0;
                right_we = 1'b1;  right_wa = r_old;    right_wd = new_leaf;
                left_we = 1'b1;   left_wa = r_old;     left_wd = new_esc;
                leaf_we = 1'b1;   leaf_wa = r_sym;     leaf_wd = new_leaf;
                w_ra    = r_old;
                n_state = S_SP1;
            end
            S_SP1: begin
                w_we = 1'b1;      w_wa = new_esc;      w_wd = '0;
                par_we = 1'b1;    par_wa = new_esc;    par_wd = r_old;
                inner_we = 1'b1;  inner_wa = new_esc;  inner_wd = 1'b0;
                par_ra  = r_old;
                n_wt    = w_rd;
                n_state = S_SP2;
            end
            S_SP2: begin
                w_we = 1'b1;      w_wa = r_old;        w_wd = r_wt + t_weight'(1);
                inner_we = 1'b1;  inner_wa = r_old;    inner_wd = 1'b1;
                n_esc  = new_esc;
                n_used = r_used + TW'(2);
                n_seen_bits[r_sym] = 1'b1;
                n_c    = rd_par;
                n_state = (r_old == '0) ? S_EMIT : S_CL0;
            end
            S_CL0: begin
                if (r_c == '0) begin
                    w_we = 1'b1;  w_wa = '0;  w_wd = r_root_w + t_weight'(1);
                    n_state = S_EMIT;
                end else begin
                    w_ra    = r_c;
                    par_ra  = r_c;
                    n_state = S_CL1;
                end
            end
            S_CL1: begin
                n_w    = w_rd;
                n_par  = rd_par;
                q_we   = 1'b1;
                q_wa   = '0;
                q_wd   = '0;
                n_head = '0;
                n_tail = TW'(1);
                n_state = S_BF0;
            end
            S_BF0: begin
                if (r_head < r_tail) begin
                    q_ra    = r_head[NW-1:0];
                    n_head  = r_head + TW'(1);
                    n_state = S_BF1;
                end else begin
                    n_m     = r_c;
                    n_state = S_SW0;
                end
            end
            S_BF1: begin
                n_x      = rd_q;
                w_ra     = rd_q;
                inner_ra = rd_q;
                right_ra = rd_q;
                n_state  = S_BF2;
            end
            S_BF2: begin
                if ((w_rd == r_w) && (r_x != r_par)) begin
                    n_m     = r_x;
                    n_state = S_SW0;
                end else if ((w_rd < r_w) || !rd_inner) begin
                    n_state = S_BF0;
                end else if (r_tail <= TW'(MAX_NODES - 2)) begin
                    q_we    = 1'b1;
                    q_wa    = r_tail[NW-1:0];
                    q_wd    = rd_right;
                    left_ra = r_x;
                    n_state = S_BF3;
                end else begin
                    n_state = S_BF0;
                end
            end
            S_BF3: begin
                q_we    = 1'b1;
                q_wa    = r_tail[NW-1:0] + NW'(1);
                q_wd    = rd_left;
                n_tail  = r_tail + TW'(2);
                n_state = S_BF0;
            end
            S_SW0: begin
                if ((r_m != r_c) && (r_m != '0)) begin
                    par_ra  = r_m;
                    left_ra = r_par;
                    n_state = S_SW1;
                end else begin
                    n_state = S_INC;
                end
            end
            S_SW1: begin
                n_pb    = rd_par;
                n_aleft = (rd_left == r_c);
                left_ra = rd_par;
                n_state = S_SW2;
            end
            S_SW2: begin
                n_bleft = (rd_left == r_m);
                if (r_aleft) begin
                    left_we = 1'b1;  left_wa = r_par;  left_wd = r_m;
                end else begin
                    right_we = 1'b1; right_wa = r_par; right_wd = r_m;
                end
                n_state = S_SW3;
            end
            S_SW3: begin
                if (r_bleft) begin
                    left_we = 1'b1;  left_wa = r_pb;  left_wd = r_c;
                end else begin
                    right_we = 1'b1; right_wa = r_pb; right_wd = r_c;
                end
                par_we  = 1'b1;
                par_wa  = r_c;
                par_wd  = r_pb;
                n_state = S_SW4;
            end
            S_SW4: begin
                par_we  = 1'b1;
                par_wa  = r_m;
                par_wd  = r_par;
                n_par   = r_pb;
                n_state = S_INC;
            end
            S_INC: begin
                w_we    = 1'b1;
                w_wa    = r_c;
                w_wd    = r_w + t_weight'(1);
                n_c     = r_par;
                n_guard = r_guard + TW'(1);
                n_state = (r_guard == TW'(MAX_NODES - 1)) ? S_EMIT : S_CL0;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (r_depth != '0) begin
                        n_shift = {r_shift[MAX_NODES-2:0], 1'b0};
                        n_depth = r_depth - TW'(1);
                    end else begin
                        n_raw = {r_raw[SB-2:0], 1'b0};
                    end
                    n_rem   = r_rem - RW'(1);
                    n_chunk = sh_chunk;
                    n_cnt   = r_cnt + CW'(1);
                    if ((r_rem == RW'(1)) || (r_cnt == CW'(CHUNK_BITS - 1))) begin
                        n_out_valid = 1'b1;
                        n_out_chunk = sh_chunk;
                        n_out_bits  = r_cnt + CW'(1);
                        n_out_last  = (r_rem == RW'(1));
                        n_out_ovf   = r_ovf;
                        n_chunk     = '0;
                        n_cnt       = '0;
                        if (r_rem == RW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_root_w = (w_we && (w_wa == '0)) ? w_wd : r_root_w;
        n_w_ra0  = (w_ra == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ovf       <= 1'b0;
            r_root_w    <= '0;
            r_used      <= TW'(1);
            r_esc       <= '0;
            r_seen_bits <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ovf       <= n_ovf;
            r_root_w    <= n_root_w;
            r_used      <= n_used;
            r_esc       <= n_esc;
            r_seen_bits <= n_seen_bits;
        end
        r_sym <= n_sym;  r_raw <= n_raw;  r_seen <= n_seen;
        r_n <= n_n;  r_p <= n_p;  r_leaf <= n_leaf;  r_old <= n_old;
        r_c <= n_c;  r_par <= n_par;  r_x <= n_x;  r_m <= n_m;  r_pb <= n_pb;
        r_depth <= n_depth;  r_guard <= n_guard;  r_head <= n_head;  r_tail <= n_tail;
        r_shift <= n_shift;  r_aleft <= n_aleft;  r_bleft <= n_bleft;
        r_w_ra0 <= n_w_ra0;  r_wt <= n_wt;  r_w <= n_w;  r_rem <= n_rem;
        r_chunk <= n_chunk;  r_cnt <= n_cnt;
        r_out_chunk <= n_out_chunk;  r_out_bits <= n_out_bits;
        r_out_last <= n_out_last;  r_out_ovf <= n_out_ovf;
    end
endmodule

>>> rtl/adaptive_huffman_encoder_core.sv
// Sequence: the code walk climbs from the symbol's leaf, or the escape leaf, to the root;
// then the tree update (a split for a new symbol; per level a breadth-first leader search
// that queues children, a swap where needed, and the weight increment); then one code bit
// per cycle is emitted while the output is not stalled. Requests pass one at a time through
// the tree sequencer; a two-entry queue takes the next request.
// Synchronous active-low reset clears control state only; tree memories need no clearing.
module adaptive_huffman_encoder_core #(
    parameter int SYMBOL_BITS = 7,
    parameter int MAX_NODES   = 256,
    parameter int CHUNK_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SYMBOL_BITS-1:0]          i_symbol,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [CHUNK_BITS-1:0]           o_code_chunk,
    output logic [$clog2(CHUNK_BITS+1)-1:0] o_chunk_bits,
    output logic                            o_last_chunk,
    output logic                            o_overflow
);
    logic                   q_valid;
    logic [SYMBOL_BITS-1:0] q_symbol;
    logic                   q_pop;

    huffenc_front #(.SYMBOL_BITS(SYMBOL_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_symbol   (i_symbol),
        .o_q_valid  (q_valid),
        .o_q_symbol (q_symbol),
        .i_q_pop    (q_pop)
    );

    huffenc_back #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .MAX_NODES   (MAX_NODES),
        .CHUNK_BITS  (CHUNK_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_symbol   (q_symbol),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_chunk (o_code_chunk),
        .o_chunk_bits (o_chunk_bits),
        .o_last_chunk (o_last_chunk),
        .o_overflow   (o_overflow)
    );
endmodule

>>> rtl/huffenc_chk.sv
`include "adaptive_huffman_encoder_core_macros.svh"

module huffenc_chk #(
    parameter int CHUNK_BITS = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [$clog2(CHUNK_BITS+1)-1:0] o_chunk_bits,
    input logic                            o_last_chunk,
    input logic                            o_overflow
);
    `HUFFENC_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `HUFFENC_ASSERT(a_bits_range, o_out_valid |-> (o_chunk_bits != '0) && (o_chunk_bits <= ($clog2(CHUNK_BITS+1))'(CHUNK_BITS)), "chunk size out of range")
    `HUFFENC_ASSERT(a_full_chunk, o_out_valid && !o_last_chunk |-> o_chunk_bits == ($clog2(CHUNK_BITS+1))'(CHUNK_BITS), "short chunk before last")
    `HUFFENC_ASSERT(a_ovf_sticky, $past(o_out_valid && !i_out_stall && o_overflow) && o_out_valid |-> o_overflow, "overflow flag dropped")
endmodule

bind adaptive_huffman_encoder_core huffenc_chk #(.CHUNK_BITS(CHUNK_BITS)) u_chk (.*);

>>> bench/adaptive_huffman_encoder_core_tb.sv
`timescale 1ns / 1ps

module adaptive_huffman_encoder_core_tb;
    import huffenc_pkg::*;

    localparam int SYM_W     = 7;
    localparam int NODES     = 256;
    localparam int CHUNK_W   = 16;
    localparam int NSYM      = 1 << SYM_W;
    localparam int ROOT      = 0;
    localparam int DRAIN_CYC = 4000;
    localparam longint LIMIT = 64'd40_000_000;

    typedef struct {
        logic [CHUNK_W-1:0] chunk;
        logic [4:0]         bits;
        logic               last;
        logic               ovf;
    } t_chunk;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [SYM_W-1:0]   i_symbol = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [CHUNK_W-1:0] o_code_chunk;
    logic [4:0]         o_chunk_bits;
    logic               o_last_chunk;
    logic               o_overflow;

    adaptive_huffman_encoder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_symbol(i_symbol),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_code_chunk(o_code_chunk), .o_chunk_bits(o_chunk_bits),
        .o_last_chunk(o_last_chunk), .o_overflow(o_overflow)
    );

    initial forever #10 i_clk = ~i_clk;

    // tree mirror
    t_weight    tree_weight [NODES];
    logic [8:0] tree_parent [NODES];
    logic [8:0] tree_left   [NODES];
    logic [8:0] tree_right  [NODES];
    bit         tree_inner  [NODES];
    logic [8:0] leaf_of     [NSYM];
    bit         seen        [NSYM];
    logic [8:0] nyt_leaf;
    logic [9:0] used_nodes;
    bit         saturated;

    t_chunk pending_chunks[$];
    int     errors = 0;
    bit     quiet = 1'b0;
    longint cycles = 0;

    task automatic tree_reset();
        for (int i = 0; i < NODES; i++) begin
            tree_weight[i] = '0; tree_parent[i] = '0; tree_left[i] = '0;
            tree_right[i] = '0; tree_inner[i] = 1'b0;
        end
        for (int i = 0; i < NSYM; i++) begin
            leaf_of[i] = '0; seen[i] = 1'b0;
        end
        nyt_leaf = 9'(ROOT); used_nodes = 10'd1; saturated = 1'b0;
    endtask

    function automatic logic [8:0] block_leader(logic [8:0] c);
        logic [8:0] q [NODES];
        int head, tail;
        t_weight w;
        logic [8:0] x;
        w = tree_weight[c];
        head = 0; tail = 0;
        q[tail++] = 9'(ROOT);
        while (head < tail) begin
            x = q[head++];
            if (tree_weight[x] == w && (c == ROOT || x != tree_parent[c])) return x;
            if (tree_weight[x] < w || !tree_inner[x]) continue;
            if (tail + 2 <= NODES) begin
                q[tail++] = tree_right[x];
                q[tail++] = tree_left[x];
            end
        end
        return c;
    endfunction

    task automatic swap_subtrees(logic [8:0] a, logic [8:0] b);
        logic [8:0] pa, pb;
        bit al, bl;
        pa = tree_parent[a]; pb = tree_parent[b];
        al = tree_left[pa] == a;
        bl = tree_left[pb] == b;
        if (al) tree_left[pa] = b; else tree_right[pa] = b;
        if (bl) tree_left[pb] = a; else tree_right[pb] = a;
        tree_parent[a] = pb;
        tree_parent[b] = pa;
    endtask

    task automatic fgk_climb(logic [8:0] c);
        logic [8:0] m;
        for (int g = 0; g < NODES; g++) begin
            m = block_leader(c);
            if (m != c && c != ROOT && m != ROOT) swap_subtrees(c, m);
            tree_weight[c] = tree_weight[c] + t_weight'(1);
            if (c == ROOT) break;
            c = tree_parent[c];
        end
    endtask

    task automatic tree_update(logic [SYM_W-1:0] s);
        logic [8:0] old, lf, esc;
        if (saturated || tree_weight[ROOT] == WEIGHT_MAX) begin
            saturated = 1'b1;
            return;
        end
        if (seen[s]) begin
            fgk_climb(leaf_of[s]);
            return;
        end
        if (used_nodes + 2 > NODES) return;
        old = nyt_leaf; lf = used_nodes[8:0]; esc = used_nodes[8:0] + 9'd1;
        used_nodes = used_nodes + 10'd2;
        tree_weight[lf] = t_weight'(1); tree_parent[lf] = old; tree_inner[lf] = 1'b0;
        tree_weight[esc] = '0; tree_parent[esc] = old; tree_inner[esc] = 1'b0;
        tree_right[old] = lf; tree_left[old] = esc; tree_inner[old] = 1'b1;
        tree_weight[old] = tree_weight[old] + t_weight'(1);
        nyt_leaf = esc; seen[s] = 1'b1; leaf_of[s] = lf;
        if (old != ROOT) fgk_climb(tree_parent[old]);
    endtask

    task automatic encode_symbol(logic [SYM_W-1:0] s);
        bit code[$];
        bit known;
        logic [8:0] n, p;
        int d, take;
        t_chunk e;
        known = seen[s];
        n = known ? leaf_of[s] : nyt_leaf;
        d = 0;
        while (n != ROOT && d < NODES) begin
            p = tree_parent[n];
            code.push_front(tree_right[p] == n);
            d++;
            n = p;
        end
        if (!known) for (int i = SYM_W - 1; i >= 0; i--) code.insert(code.size(), s[i]);
        tree_update(s);
        for (int pos = 0; pos < code.size(); pos += CHUNK_W) begin
            take = code.size() - pos;
            if (take > CHUNK_W) take = CHUNK_W;
            e.chunk = '0;
            for (int i = 0; i < take; i++) e.chunk = {e.chunk[CHUNK_W-2:0], code[pos+i]};
            e.bits = take[4:0];
            e.last = (pos + take >= code.size());
            e.ovf  = saturated;
            pending_chunks.insert(pending_chunks.size(), e);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_chunk e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chunks.size() == 0) begin
                errors++;
                $display("%0t: unexpected chunk %h/%0d", $time, o_code_chunk, o_chunk_bits);
            end else begin
                e = pending_chunks.pop_front();
                if (o_code_chunk !== e.chunk || o_chunk_bits !== e.bits ||
                    o_last_chunk !== e.last || o_overflow !== e.ovf) begin
                    errors++;
                    $display("%0t: expected %h/%0d last %b ovf %b, actual %h/%0d last %b ovf %b",
                             $time, e.chunk, e.bits, e.last, e.ovf,
                             o_code_chunk, o_chunk_bits, o_last_chunk, o_overflow);
                end
            end
        end
    end

    // receiver back-pressure in bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("adaptive_huffman_encoder_core regression: fail");
            $finish;
        end
    end

    task automatic send_symbol(logic [SYM_W-1:0] s);
        i_in_valid <= 1'b1;
        i_symbol   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        encode_symbol(s);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        logic [SYM_W-1:0] list [$] = '{0, 127, 0, 127, 7'h55, 7'h2a, 0, 1, 64, 63,
                                       127, 0, 0, 1, 1, 64, 2, 3, 126, 0};
        foreach (list[i]) send_symbol(list[i]);
    endtask

    task automatic test_skewed_stream();
        for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 9) < 7) send_symbol(SYM_W'($urandom_range(0, 11)));
            else send_symbol(SYM_W'($urandom));
        end
    endtask

    task automatic test_drain_pause();
        i_in_valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat ($urandom_range(1, 40)) @(posedge i_clk);
    endtask

    // every symbol once, the last one twice more: the store fills and the last unseen one stays escaped
    task automatic test_fill_store();
        logic [SYM_W-1:0] order [NSYM];
        logic [SYM_W-1:0] t;
        int j;
        for (int i = 0; i < NSYM; i++) order[i] = SYM_W'(i);
        for (int i = NSYM - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        foreach (order[i]) send_symbol(order[i]);
        send_symbol(order[NSYM-1]);
        send_symbol(order[NSYM-1]);
    endtask

    task automatic test_tail_no_gaps();
        quiet = 1'b1;
        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(0, 1) == 0) send_symbol(SYM_W'($urandom_range(0, 15)));
            else send_symbol(SYM_W'($urandom));
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        tree_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_skewed_stream();
        test_drain_pause();
        test_fill_store();
        test_drain_pause();
        test_tail_no_gaps();
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0 && pending_chunks.size() == 0) begin
            $display("adaptive_huffman_encoder_core regression: pass");
        end else begin
            $display("adaptive_huffman_encoder_core regression: fail");
        end
        $finish;
    end
endmodule
